// ===== hdl/bra_pkg.sv =====
// Shared types and constants for the bitmap run allocator.
package bra_pkg;
   localparam int unsigned NumEntries = 65536;
   localparam int unsigned WordCount  = NumEntries / 32;
   localparam int unsigned WaddrW     = $clog2(WordCount);
   localparam int unsigned IdxW       = $clog2(NumEntries);
   localparam int unsigned CntW       = IdxW + 1;

   typedef enum logic [2:0] {
      OP_GET      = 3'd0,
      OP_PUT      = 3'd1,
      OP_TAKE     = 3'd2,
      OP_READ     = 3'd3,
      OP_FREE_ALL = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_NO_SPACE      = 3'd1,
      ST_ALREADY_FREE  = 3'd2,
      ST_ALREADY_TAKEN = 3'd3,
      ST_RANGE         = 3'd4
   } status_type;

   typedef struct packed {
      logic       load;
      logic       get_init;
      logic       scan_rd;
      logic       scan_step;
      logic       claim_rd;
      logic       claim_wr;
      logic       op_rd;
      logic       op_exec;
      logic       fill_init;
      logic       fill_wr;
      logic       clear_wr;
      logic       emit;
      logic       set_st;
      status_type st;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       idx_range;
      logic       pre_fail;
      logic       scan_fail;
      logic       scan_hit;
      logic       word_end;
      logic       claim_last;
      logic       fill_last;
      logic       clear_last;
   } sts_type;
endpackage

// ===== hdl/bra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bra_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/bra_dp.sv =====
// Datapath: request registers, bitmap memory, scan and claim counters.
module bra_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  bra_pkg::cmd_type     cmd,
   output bra_pkg::sts_type     sts,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [16:0]          csr_data,
   input  logic [2:0]           req_op,
   input  logic [15:0]          req_entry_index,
   input  logic [16:0]          req_run_length,
   input  logic [16:0]          req_alignment,
   input  logic [16:0]          req_limit,
   output logic [2:0]           rsp_status,
   output logic [15:0]          rsp_start_index,
   output logic                 rsp_bit_value
);
   import bra_pkg::*;

   logic [CntW-1:0]   active_ff, active_in;
   logic [2:0]        op_ff;
   logic [IdxW-1:0]   idx_ff;
   logic [CntW-1:0]   len_ff, align_ff, lim_ff, bound_ff, bound_in;
   logic [CntW-1:0]   i_ff, i_in, found_ff, found_in;
   logic [CntW:0]     nal_ff, nal_in;
   logic [IdxW-1:0]   start_ff, start_in;
   logic [WaddrW-1:0] cw_ff, cw_in;
   status_type        res_st_ff, res_st_in;
   logic              res_bit_ff, res_bit_in;
   logic [2:0]        out_st_ff;
   logic [IdxW-1:0]   out_start_ff;
   logic              out_bit_ff;

   logic [17:0]       csr_round;
   logic              wr_en, rd_en;
   logic [WaddrW-1:0] wr_addr, rd_addr;
   logic [31:0]       wr_data, rd_data;

   logic              b, skip, first, fail_bound, catch_up, cand, hit, advance;
   logic [CntW-1:0]   i_next;
   logic [IdxW-1:0]   end_idx;
   logic [31:0]       mask_lo, mask_hi, bitsel;
   logic [4:0]        lo, hi;

   bra_ram #(.Width(32), .Depth(WordCount)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign csr_round = ({1'b0, csr_data} + 18'd31) & ~18'd31;

   always_comb begin
      active_in = active_ff;
      if (csr_valid && csr_ready) begin
         if (csr_round < 18'd32) begin
            active_in = CntW'(32);
         end else if (csr_round > 18'(NumEntries)) begin
            active_in = CntW'(NumEntries);
         end else begin
            active_in = csr_round[CntW-1:0];
         end
      end
   end

   // scan decision for the current bit
   assign b          = rd_data[i_ff[4:0]];
   assign skip       = (rd_data == 32'd0) && (i_ff[4:0] == 5'd0);
   assign first      = b && (found_ff == '0);
   assign fail_bound = first && (i_ff >= bound_ff);
   assign catch_up   = first && !fail_bound && (nal_ff < {1'b0, i_ff});
   assign cand       = first && !fail_bound && (nal_ff == {1'b0, i_ff});
   assign hit        = b && ((cand && len_ff == CntW'(1)) ||
                             (found_ff != '0 && found_ff + CntW'(1) == len_ff));
   assign advance    = !fail_bound && !catch_up && !hit;
   assign i_next     = skip ? i_ff + CntW'(32) : i_ff + CntW'(1);

   assign end_idx = start_ff + len_ff[IdxW-1:0] - IdxW'(1);
   assign lo      = (cw_ff == start_ff[IdxW-1:5]) ? start_ff[4:0] : 5'd0;
   assign hi      = (cw_ff == end_idx[IdxW-1:5]) ? end_idx[4:0] : 5'd31;
   assign mask_lo = 32'hFFFFFFFF << lo;
   assign mask_hi = 32'hFFFFFFFF >> (5'd31 - hi);
   assign bitsel  = 32'd1 << idx_ff[4:0];

   always_comb begin
      sts.op         = op_ff;
      sts.idx_range  = {1'b0, idx_ff} >= active_ff;
      sts.pre_fail   = (len_ff == '0) || (lim_ff != '0 && lim_ff <= len_ff);
      sts.scan_fail  = fail_bound || (advance && i_next >= active_ff);
      sts.scan_hit   = hit;
      sts.word_end   = advance && (i_next[4:0] == 5'd0);
      sts.claim_last = (cw_ff == end_idx[IdxW-1:5]);
      sts.fill_last  = ({1'b0, cw_ff} == active_ff[CntW-1:5] - 12'd1);
      sts.clear_last = (cw_ff == WaddrW'(WordCount - 1));
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cw_ff;
      wr_data = 32'd0;
      rd_en   = 1'b0;
      rd_addr = cw_ff;
      if (cmd.scan_rd) begin
         rd_en   = 1'b1;
         rd_addr = i_ff[IdxW-1:5];
      end
      if (cmd.claim_rd) begin
         rd_en = 1'b1;
      end
      if (cmd.op_rd) begin
         rd_en   = 1'b1;
         rd_addr = idx_ff[IdxW-1:5];
      end
      if (cmd.claim_wr) begin
         wr_en   = 1'b1;
         wr_data = rd_data & ~(mask_lo & mask_hi);
      end
      if (cmd.fill_wr) begin
         wr_en   = 1'b1;
         wr_data = 32'hFFFFFFFF;
      end
      if (cmd.clear_wr) begin
         wr_en = 1'b1;
      end
      if (cmd.op_exec) begin
         wr_addr = idx_ff[IdxW-1:5];
         if (op_ff == OP_PUT && !(|(rd_data & bitsel))) begin
            wr_en   = 1'b1;
            wr_data = rd_data | bitsel;
         end
         if (op_ff == OP_TAKE && (|(rd_data & bitsel))) begin
            wr_en   = 1'b1;
            wr_data = rd_data & ~bitsel;
         end
      end
   end

   always_comb begin
      i_in       = i_ff;
      found_in   = found_ff;
      nal_in     = nal_ff;
      start_in   = start_ff;
      cw_in      = cw_ff;
      bound_in   = bound_ff;
      res_st_in  = res_st_ff;
      res_bit_in = res_bit_ff;
      if (cmd.load) begin
         res_st_in  = ST_OK;
         res_bit_in = 1'b0;
         start_in   = '0;
      end
      if (cmd.get_init) begin
         i_in     = '0;
         found_in = '0;
         nal_in   = '0;
         bound_in = active_ff;
         if (lim_ff != '0 && lim_ff - len_ff < active_ff) begin
            bound_in = lim_ff - len_ff;
         end
      end
      if (cmd.scan_step) begin
         if (catch_up) begin
            nal_in = nal_ff + {1'b0, align_ff};
         end else if (fail_bound) begin
            start_in = '0;
         end else if (hit) begin
            if (cand) begin
               start_in = i_ff[IdxW-1:0];
            end
            cw_in = cand ? i_ff[IdxW-1:5] : start_ff[IdxW-1:5];
         end else begin
            i_in = i_next;
            if (skip || !b) begin
               found_in = '0;
            end else if (cand) begin
               start_in = i_ff[IdxW-1:0];
               found_in = CntW'(1);
            end else if (found_ff != '0) begin
               found_in = found_ff + CntW'(1);
            end
         end
      end
      if (cmd.claim_wr || cmd.fill_wr || cmd.clear_wr) begin
         cw_in = cw_ff + WaddrW'(1);
      end
      if (cmd.fill_init) begin
         cw_in = '0;
      end
      if (cmd.op_exec) begin
         unique case (op_ff)
            OP_PUT:  if (|(rd_data & bitsel)) res_st_in = ST_ALREADY_FREE;
            OP_TAKE: if (!(|(rd_data & bitsel))) res_st_in = ST_ALREADY_TAKEN;
            OP_READ: res_bit_in = |(rd_data & bitsel);
            default: res_st_in = ST_OK;
         endcase
      end
      if (cmd.set_st) begin
         res_st_in = cmd.st;
         if (cmd.st == ST_NO_SPACE) begin
            start_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= CntW'(NumEntries);
         cw_ff     <= '0;
      end else begin
         active_ff <= active_in;
         cw_ff     <= cw_in;
      end
      if (cmd.load) begin
         op_ff    <= req_op;
         idx_ff   <= req_entry_index;
         len_ff   <= req_run_length;
         align_ff <= (req_alignment == '0) ? CntW'(1) : req_alignment;
         lim_ff   <= req_limit;
      end
      i_ff       <= i_in;
      found_ff   <= found_in;
      nal_ff     <= nal_in;
      start_ff   <= start_in;
      bound_ff   <= bound_in;
      res_st_ff  <= res_st_in;
      res_bit_ff <= res_bit_in;
      if (cmd.emit) begin
         out_st_ff    <= res_st_ff;
         out_start_ff <= start_ff;
         out_bit_ff   <= res_bit_ff;
      end
   end

   assign rsp_status      = out_st_ff;
   assign rsp_start_index = out_start_ff;
   assign rsp_bit_value   = out_bit_ff;
endmodule

// ===== hdl/bra_ctrl.sv =====
// Controller: sequences clear, scan, claim, update and fill operations.
module bra_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bra_pkg::cmd_type cmd,
   input  bra_pkg::sts_type sts
);
   import bra_pkg::*;

   typedef enum logic [10:0] {
      S_CLEAR = 11'b00000000001,
      S_IDLE  = 11'b00000000010,
      S_DISP  = 11'b00000000100,
      S_GRD   = 11'b00000001000,
      S_GBIT  = 11'b00000010000,
      S_CRD   = 11'b00000100000,
      S_CWR   = 11'b00001000000,
      S_OEX   = 11'b00010000000,
      S_FILL  = 11'b00100000000,
      S_DONE  = 11'b01000000000,
      S_SPARE = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.st   = ST_OK;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            unique case (sts.op)
               OP_GET: begin
                  if (sts.pre_fail) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = ST_NO_SPACE;
                     state_in   = S_DONE;
                  end else begin
                     cmd.get_init = 1'b1;
                     state_in     = S_GRD;
                  end
               end
               OP_PUT, OP_TAKE, OP_READ: begin
                  if (sts.idx_range) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = ST_RANGE;
                     state_in   = S_DONE;
                  end else begin
                     cmd.op_rd = 1'b1;
                     state_in  = S_OEX;
                  end
               end
               OP_FREE_ALL: begin
                  cmd.fill_init = 1'b1;
                  state_in      = S_FILL;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_GRD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_GBIT;
         end
         S_GBIT: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_fail) begin
               cmd.set_st = 1'b1;
               cmd.st     = ST_NO_SPACE;
               state_in   = S_DONE;
            end else if (sts.scan_hit) begin
               state_in = S_CRD;
            end else if (sts.word_end) begin
               state_in = S_GRD;
            end
         end
         S_CRD: begin
            cmd.claim_rd = 1'b1;
            state_in     = S_CWR;
         end
         S_CWR: begin
            cmd.claim_wr = 1'b1;
            state_in     = sts.claim_last ? S_DONE : S_CRD;
         end
         S_OEX: begin
            cmd.op_exec = 1'b1;
            state_in    = S_DONE;
         end
         S_FILL: begin
            cmd.fill_wr = 1'b1;
            if (sts.fill_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_DISP))
      else $error("accepted request not dispatched");
   a_hit_claims: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GBIT && sts.scan_hit && !sts.scan_fail) |=> (state_ff == S_CRD))
      else $error("scan hit did not start claim");
   a_emit_frees_out: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("emit did not present response");
endmodule

// ===== hdl/bitmap_run_allocator_top.sv =====
// Top level of the bitmap run allocator.
// Request channel (req_*): op, entry_index, run_length, alignment, limit.
// A request is taken when req_valid is high and req_stall is low.
// Response channel (rsp_*): status, start_index, bit_value; one response
// per request, taken when rsp_valid is high and rsp_stall is low.
// csr_* writes active_entries (rounded up to a multiple of 32, clamped to 32..65536)
// whenever csr_valid is high; csr_ready is always high.
// One request is processed at a time; the response becomes valid in the
// same cycle that the next request can be taken. Put, take and read step
// through load, dispatch, word read, update and emit; free all writes one
// word per 32 active entries; gets rejected up front go straight to emit;
// other gets scan, then read and write back each claimed 32-bit word. The
// scan reads each bitmap word, examines each bit (an all-taken word needs
// only its first) and steps through each alignment candidate passed.
// After reset a pass over all 2048 words clears the bitmap (every entry taken);
// req_stall stays high until it ends.
// When the receiver stalls, the response is held in its output register
// and the next request may still be taken; it completes once the
// output register is free.
module bitmap_run_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [15:0] req_entry_index,
   input  logic [16:0] req_run_length,
   input  logic [16:0] req_alignment,
   input  logic [16:0] req_limit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_start_index,
   output logic        rsp_bit_value
);
   import bra_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   bra_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd),
      .sts      (sts)
   );

   bra_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .req_op         (req_op),
      .req_entry_index(req_entry_index),
      .req_run_length (req_run_length),
      .req_alignment  (req_alignment),
      .req_limit      (req_limit),
      .rsp_status     (rsp_status),
      .rsp_start_index(rsp_start_index),
      .rsp_bit_value  (rsp_bit_value)
   );
endmodule

// ===== sim/tb.sv =====
// Testbench for bitmap_run_allocator_top: random and directed requests checked by a scoreboard.
module tb;
   import bra_pkg::*;

   class alloc_scoreboard;
      typedef struct {
         status_type  status;
         logic [15:0] start;
         logic        bitv;
      } alloc_rsp_type;

      bit            free_map[NumEntries];
      int unsigned   active;
      alloc_rsp_type pending_rsp[$];
      int            errors;
      int            requests;
      int            gets_claimed;
      int            responses;

      function new();
         foreach (free_map[i]) free_map[i] = 0;
         active = NumEntries;
         errors = 0;
         requests = 0;
         gets_claimed = 0;
         responses = 0;
      endfunction

      function void set_active(logic [16:0] v);
         int unsigned a;
         a = v;
         a = (a + 31) & ~32'd31;
         if (a < 32) a = 32;
         if (a > NumEntries) a = NumEntries;
         active = a;
      endfunction

      function bit claim_run(int unsigned len, int unsigned align, int unsigned limit,
                             output int unsigned start);
         int unsigned bound;
         int unsigned found;
         bound = active;
         found = 0;
         start = 0;
         if (len == 0) return 0;
         if (align == 0) align = 1;
         if (limit != 0) begin
            if (limit <= len) return 0;
            if (limit - len < bound) bound = limit - len;
         end
         for (int unsigned i = 0; i < active; i++) begin
            if (free_map[i]) begin
               if (found == 0) begin
                  if (i >= bound) return 0;
                  if (i % align != 0) continue;
                  start = i;
               end
               found++;
               if (found == len) begin
                  for (int unsigned k = 0; k < len; k++) free_map[start + k] = 0;
                  return 1;
               end
            end else begin
               found = 0;
            end
         end
         return 0;
      endfunction

      function void note_request(logic [2:0] op, logic [15:0] idx, logic [16:0] len,
                                 logic [16:0] align, logic [16:0] limit);
         alloc_rsp_type e;
         int unsigned   s;
         e.status = ST_OK;
         e.start = '0;
         e.bitv = 1'b0;
         requests++;
         case (op)
            OP_GET: begin
               if (claim_run(len, align, limit, s)) begin
                  e.start = s[15:0];
                  gets_claimed++;
               end else begin
                  e.status = ST_NO_SPACE;
               end
            end
            OP_PUT: begin
               if (idx >= active) e.status = ST_RANGE;
               else if (free_map[idx]) e.status = ST_ALREADY_FREE;
               else free_map[idx] = 1;
            end
            OP_TAKE: begin
               if (idx >= active) e.status = ST_RANGE;
               else if (!free_map[idx]) e.status = ST_ALREADY_TAKEN;
               else free_map[idx] = 0;
            end
            OP_READ: begin
               if (idx >= active) e.status = ST_RANGE;
               else e.bitv = free_map[idx];
            end
            OP_FREE_ALL: begin
               for (int unsigned i = 0; i < active; i++) free_map[i] = 1;
            end
            default: ;
         endcase
         pending_rsp.push_back(e);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 50) $display("mismatch: %s", msg);
      endtask

      task check_response(logic [2:0] st, logic [15:0] start, logic bitv);
         alloc_rsp_type e;
         responses++;
         if (pending_rsp.size() == 0) begin
            report("response with no request outstanding");
         end else begin
            e = pending_rsp.pop_front();
            if (st !== e.status)
               report($sformatf("rsp %0d status %0d, want %0d", responses, st, e.status));
            if (start !== e.start)
               report($sformatf("rsp %0d start %0d, want %0d", responses, start, e.start));
            if (bitv !== e.bitv)
               report($sformatf("rsp %0d bit %0b, want %0b", responses, bitv, e.bitv));
         end
      endtask

      function int pending();
         return pending_rsp.size();
      endfunction
   endclass

   localparam int          Limit   = 30000000;
   localparam logic [2:0]  OpSpare = 3'd5;
   localparam logic [2:0]  OpLast  = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [16:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_op = '0;
   logic [15:0] req_entry_index = '0;
   logic [16:0] req_run_length = '0;
   logic [16:0] req_alignment = '0;
   logic [16:0] req_limit = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_start_index;
   logic        rsp_bit_value;

   alloc_scoreboard sb = new();
   int cycles = 0;
   bit calm = 0;
   bit hold_request = 0;
   int long_hold_left = 0;
   int stall_left = 0;
   int rnd;
   bit stall_next;

   bitmap_run_allocator_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > Limit) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_status, rsp_start_index, rsp_bit_value);
      if (hold_request) begin
         hold_request = 0;
         long_hold_left = 400;
      end
      if (long_hold_left > 0) begin
         long_hold_left--;
         stall_next = 1'b1;
      end else if (calm) begin
         stall_next = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         stall_next = 1'b1;
      end else begin
         rnd = $urandom_range(0, 99);
         stall_next = (rnd < 20);
         if (rnd < 2) stall_left = $urandom_range(20, 60);
         else if (rnd < 20) stall_left = $urandom_range(0, 2);
      end
      rsp_stall <= stall_next;
   end

   task send_req(logic [2:0] op, logic [15:0] idx, logic [16:0] len,
                 logic [16:0] align, logic [16:0] limit);
      int gap;
      int r;
      gap = 0;
      if (!calm) begin
         r = $urandom_range(0, 99);
         if (r < 10) gap = $urandom_range(10, 40);
         else if (r < 50) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_entry_index <= idx;
      req_run_length <= len;
      req_alignment <= align;
      req_limit <= limit;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, idx, len, align, limit);
   endtask

   task send_random();
      logic [2:0]  op;
      logic [15:0] idx;
      logic [16:0] len;
      logic [16:0] align;
      logic [16:0] limit;
      int r;
      r = $urandom_range(0, 99);
      if (r < 38) op = OP_GET;
      else if (r < 60) op = OP_PUT;
      else if (r < 74) op = OP_TAKE;
      else if (r < 88) op = OP_READ;
      else if (r < 93) op = OP_FREE_ALL;
      else op = OpSpare + 3'($urandom_range(0, 2));
      idx = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, sb.active - 1))
                                          : 16'($urandom);
      r = $urandom_range(0, 99);
      len = (r < 80) ? 17'($urandom_range(1, 40)) : (r < 90) ? 17'($urandom) : 17'd1;
      r = $urandom_range(0, 99);
      if (r < 70) align = 17'd1 << $urandom_range(0, 5);
      else if (r < 75) align = '0;
      else if (r < 85) align = 17'($urandom);
      else align = 17'($urandom_range(1, 12));
      r = $urandom_range(0, 99);
      if (r < 50) limit = '0;
      else if (r < 85) limit = 17'($urandom_range(0, sb.active + 64));
      else limit = 17'($urandom);
      send_req(op, idx, len, align, limit);
   endtask

   task wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task write_active(logic [16:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_active(v);
   endtask

   logic [16:0] settings[6] = '{17'd32, 17'd100, 17'd1000, 17'd0, 17'd4096, 17'h1FFFF};
   int          counts[6]   = '{50, 55, 60, 40, 45, 20};

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_req(OP_READ, 16'd0, 17'd1, 17'd1, 17'd0);
      send_req(OP_PUT, 16'd0, 17'd1, 17'd1, 17'd0);
      send_req(OP_PUT, 16'd0, 17'd1, 17'd1, 17'd0);
      send_req(OP_TAKE, 16'd0, 17'd1, 17'd1, 17'd0);
      send_req(OP_TAKE, 16'd0, 17'd1, 17'd1, 17'd0);
      send_req(OP_GET, 16'd0, 17'd1, 17'd1, 17'd0);
      send_req(OP_GET, 16'd0, 17'd0, 17'd1, 17'd0);
      send_req(OpSpare, 16'hFFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
      send_req(OpLast, 16'd0, 17'd1, 17'd1, 17'd0);
      send_req(OP_FREE_ALL, 16'd0, 17'd0, 17'd0, 17'd0);
      send_req(OP_READ, 16'hFFFF, 17'd1, 17'd1, 17'd0);
      send_req(OP_GET, 16'd0, 17'd65536, 17'd0, 17'd0);
      send_req(OP_READ, 16'hFFFF, 17'd1, 17'd1, 17'd0);
      send_req(OP_FREE_ALL, 16'd0, 17'd0, 17'd0, 17'd0);
      send_req(OP_GET, 16'd0, 17'd1, 17'd1, 17'd1);
      send_req(OP_GET, 16'd0, 17'd16, 17'd65536, 17'd0);
      send_req(OP_GET, 16'd0, 17'd32, 17'd32, 17'd100);
      send_req(OP_GET, 16'd0, 17'd5, 17'd3, 17'd65536);
      send_req(OP_TAKE, 16'd7, 17'd1, 17'd1, 17'd0);
      send_req(OP_PUT, 16'd20, 17'd1, 17'd1, 17'd0);
      send_req(OP_GET, 16'd0, 17'd1, 17'd0, 17'd0);
      wait_drained();

      foreach (settings[p]) begin
         write_active(settings[p]);
         calm = (p == 3);
         send_req(OP_FREE_ALL, 16'd0, 17'd0, 17'd0, 17'd0);
         if (p == 0) send_req(OP_PUT, 16'd40, 17'd1, 17'd1, 17'd0);
         if (p == 1) hold_request = 1;
         for (int n = 0; n < counts[p]; n++) begin
            if (p == 2 && n == 30) wait_drained();
            send_random();
         end
         wait_drained();
      end
      calm = 0;

      $display("covered %0d requests over %0d active_entries settings, %0d runs claimed",
               sb.requests, 7, sb.gets_claimed);
      $display("%0d responses checked, %0d mismatches", sb.responses, sb.errors);
      if (sb.errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
